/* rtl/ber_tlv_frame_extractor_assert.svh */
// assertion helpers, sampled on clk; BTLV_ASSERT is masked while rst is high
`ifndef BER_TLV_FRAME_EXTRACTOR_ASSERT_SVH
`define BER_TLV_FRAME_EXTRACTOR_ASSERT_SVH

// property that must hold at every edge outside reset
`define BTLV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// property that must hold at every edge, reset included
`define BTLV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error(msg);

`endif

/* rtl/btlv_pkg.sv */
package btlv_pkg;

  localparam int LENGTH_BITS = 16;

  localparam logic [7:0]  TAG_BYTE         = 8'h60;
  localparam logic [15:0] MAX_LENGTH_RESET = 16'd1000;

  localparam logic [1:0] KIND_DATA     = 2'd0;
  localparam logic [1:0] KIND_LAST     = 2'd1;
  localparam logic [1:0] KIND_TOO_LONG = 2'd2;
  localparam logic [1:0] KIND_EMPTY    = 2'd3;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [15:0] index;
  } result_t;

endpackage

/* rtl/btlv_in_reg.sv */
module btlv_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       consume,
  output logic       byte_valid,
  output logic [7:0] byte_q
);

  logic valid_q;

  // the held item can be replaced in the same cycle it is consumed
  assign s_tready   = !valid_q || consume;
  assign byte_valid = valid_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      valid_q <= 1'b1;
    end else if (consume) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      byte_q <= s_tdata;
    end
  end

endmodule

/* rtl/btlv_parser.sv */
`include "ber_tlv_frame_extractor_assert.svh"

module btlv_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  input  logic                byte_valid,
  input  logic [7:0]          byte_q,
  input  logic                out_ready,
  output logic                consume,
  output logic                res_valid,
  output btlv_pkg::result_t   res
);

  localparam int LB = btlv_pkg::LENGTH_BITS;

  btlv_pkg::phase_t phase, phase_next;
  logic [6:0]    length_bytes_left, length_bytes_left_next;
  logic [LB-1:0] payload_left, payload_left_next;
  logic [15:0]   payload_position, payload_position_next;
  logic [15:0]   max_length;

  logic [LB-1:0] acc;
  logic [6:0]    lbl_dec;
  logic [LB-1:0] left_dec;
  logic          acc_too_long;
  logic          acc_zero;

  assign consume = byte_valid && out_ready;

  // big-endian accumulate, wrapping at the length width
  assign acc          = {payload_left[LB-9:0], byte_q};
  assign lbl_dec      = length_bytes_left - 7'd1;
  assign left_dec     = payload_left - {{(LB-1){1'b0}}, 1'b1};
  assign acc_too_long = acc >= max_length;
  assign acc_zero     = acc == '0;

  always_comb begin
    phase_next             = phase;
    length_bytes_left_next = length_bytes_left;
    payload_left_next      = payload_left;
    payload_position_next  = payload_position;
    unique case (phase)
      btlv_pkg::PH_LEN: begin
        if (length_bytes_left == 7'd0) begin
          if (!byte_q[7]) begin
            payload_left_next     = {{(LB-8){1'b0}}, byte_q};
            payload_position_next = '0;
            phase_next = (byte_q == 8'd0) ? btlv_pkg::PH_HUNT : btlv_pkg::PH_DATA;
          end else begin
            // a count of zero leaves us reading a fresh first length byte
            length_bytes_left_next = byte_q[6:0];
            payload_left_next      = '0;
          end
        end else begin
          length_bytes_left_next = lbl_dec;
          if (lbl_dec != 7'd0) begin
            payload_left_next = acc;
          end else if (acc_too_long || acc_zero) begin
            phase_next        = btlv_pkg::PH_HUNT;
            payload_left_next = '0;
          end else begin
            phase_next            = btlv_pkg::PH_DATA;
            payload_left_next     = acc;
            payload_position_next = '0;
          end
        end
      end
      btlv_pkg::PH_DATA: begin
        if (left_dec == '0) begin
          phase_next            = btlv_pkg::PH_HUNT;
          payload_left_next     = '0;
          payload_position_next = '0;
        end else begin
          payload_left_next     = left_dec;
          payload_position_next = payload_position + 16'd1;
        end
      end
      default: begin
        length_bytes_left_next = '0;
        payload_left_next      = '0;
        payload_position_next  = '0;
        phase_next = (byte_q == btlv_pkg::TAG_BYTE) ? btlv_pkg::PH_LEN : btlv_pkg::PH_HUNT;
      end
    endcase
  end

  always_comb begin
    res_valid = 1'b0;
    res.kind  = btlv_pkg::KIND_DATA;
    res.data  = 8'd0;
    res.index = 16'd0;
    unique case (phase)
      btlv_pkg::PH_LEN: begin
        if (length_bytes_left == 7'd0) begin
          if (byte_q == 8'd0) begin
            res_valid = consume;
            res.kind  = btlv_pkg::KIND_EMPTY;
          end
        end else if (lbl_dec == 7'd0) begin
          if (acc_too_long) begin
            res_valid = consume;
            res.kind  = btlv_pkg::KIND_TOO_LONG;
          end else if (acc_zero) begin
            res_valid = consume;
            res.kind  = btlv_pkg::KIND_EMPTY;
          end
        end
      end
      btlv_pkg::PH_DATA: begin
        res_valid = consume;
        res.kind  = (left_dec == '0) ? btlv_pkg::KIND_LAST : btlv_pkg::KIND_DATA;
        res.data  = byte_q;
        res.index = payload_position;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= btlv_pkg::PH_HUNT;
      length_bytes_left <= '0;
      payload_left      <= '0;
      payload_position  <= '0;
    end else if (consume) begin
      phase             <= phase_next;
      length_bytes_left <= length_bytes_left_next;
      payload_left      <= payload_left_next;
      payload_position  <= payload_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= btlv_pkg::MAX_LENGTH_RESET;
    end else if (cfg_we) begin
      max_length <= cfg_data;
    end
  end

  `BTLV_ASSERT(a_data_has_bytes, (phase == btlv_pkg::PH_DATA) |-> (payload_left != '0), "payload phase with nothing left")
  `BTLV_ASSERT(a_count_only_in_len, (phase != btlv_pkg::PH_LEN) |-> (length_bytes_left == 7'd0), "length byte count outside length phase")
  `BTLV_ASSERT(a_result_needs_byte, res_valid |-> (byte_valid && out_ready), "result without a consumed byte")

endmodule

/* rtl/btlv_out_buf.sv */
`include "ber_tlv_frame_extractor_assert.svh"

module btlv_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  input  btlv_pkg::result_t res,
  output logic              out_ready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [23:0]       m_tdata,  // [7:0] data_byte, [23:8] byte_index
  output logic [1:0]        m_tuser   // [1:0] result_kind
);

  btlv_pkg::result_t e0, e1;
  logic [1:0] count, count_next;
  logic push, pop;

  assign out_ready = count != 2'd2;
  assign m_tvalid  = count != 2'd0;
  assign m_tdata   = {e0.index, e0.data};
  assign m_tuser   = e0.kind;
  assign push      = res_valid;
  assign pop       = m_tvalid && m_tready;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  // two entries, head always in e0
  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == 2'd2) begin
        e0 <= e1;
      end else if (push) begin
        e0 <= res;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        e0 <= res;
      end else begin
        e1 <= res;
      end
    end
  end

  `BTLV_ASSERT(a_count_range, count != 2'd3, "output buffer count out of range")
  `BTLV_ASSERT(a_no_push_full, push |-> (count != 2'd2), "item pushed into full output buffer")
  `BTLV_ASSERT(a_drain, (pop && !push && count == 2'd1) |=> (count == 2'd0), "output buffer failed to drain")

endmodule

/* rtl/ber_tlv_frame_extractor.sv */
// BER-TLV frame extractor
// s_* takes one stream byte per item in s_tdata[7:0]. The block hunts for
// the tag 0x60, reads a short or long form BER length, then passes the
// payload out on m_*: m_tuser holds the result kind (payload byte, final
// payload byte, frame too long, empty frame), m_tdata holds the payload
// byte and its index within the frame (both zero for the error kinds).
// Bytes outside a frame give no result.
// cfg_we/cfg_data write max_length; long-form lengths at or above it are
// rejected. Write it only while the block is idle.
// An accepted byte is held in the input register and parsed out of it; its
// result enters the output buffer when the parser consumes the byte, which
// waits while the output buffer is full. m_tvalid is high while it holds an item.
// Throughput: one byte per cycle while the output buffer has room.
// Reset (rst, synchronous) returns to hunting, empties both buffers and
// sets max_length to 1000.
// When m_tready is low the two-entry output buffer fills, then the parser
// stops consuming and s_tready drops once the input register is full.
module ber_tlv_frame_extractor (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] data_byte, [23:8] byte_index
  output logic [1:0]  m_tuser,   // [1:0] result_kind
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);

  logic              consume;
  logic              byte_valid;
  logic [7:0]        byte_q;
  logic              out_ready;
  logic              res_valid;
  btlv_pkg::result_t res;

  btlv_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .consume    (consume),
    .byte_valid (byte_valid),
    .byte_q     (byte_q)
  );

  btlv_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .byte_valid (byte_valid),
    .byte_q     (byte_q),
    .out_ready  (out_ready),
    .consume    (consume),
    .res_valid  (res_valid),
    .res        (res)
  );

  btlv_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_ready (out_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import btlv_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [7:0] LONG_FORM = 8'h80;

  typedef enum logic [1:0] {
    CHK_PRED,
    CHK_QUIET,
    CHK_TYPED
  } chk_t;

  typedef struct packed {
    logic [7:0] b;
    chk_t       how;
    result_t    want;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] in_byte
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // [7:0] data_byte, [23:8] byte_index
  logic [1:0]  m_tuser;   // [1:0] result_kind
  logic        cfg_we;
  logic [15:0] cfg_data;

  // frame parser state as seen by the testbench
  phase_t      ph;
  logic [6:0]  len_left;
  logic [15:0] pay_left;
  logic [15:0] pay_pos;
  logic [15:0] max_len;

  result_t pending_results[$];
  int      errors = 0;
  int      sent_items = 0;
  int      cycles = 0;
  bit      tx_idle = 1'b1;
  bit      rx_idle = 1'b1;

  localparam stim_row_t DIRECTED [23] = '{
    '{8'h5F, CHK_QUIET, '0},
    '{8'hFF, CHK_QUIET, '0},
    '{TAG_BYTE, CHK_QUIET, '0},
    '{8'h00, CHK_TYPED, '{KIND_EMPTY, 8'h00, 16'h0000}},
    '{TAG_BYTE, CHK_QUIET, '0},
    '{LONG_FORM, CHK_QUIET, '0},              // zero count, next byte reread
    '{8'h02, CHK_QUIET, '0},
    '{8'h00, CHK_TYPED, '{KIND_DATA, 8'h00, 16'h0000}},
    '{8'hFF, CHK_TYPED, '{KIND_LAST, 8'hFF, 16'h0001}},
    '{TAG_BYTE, CHK_QUIET, '0},               // tag directly after frame end
    '{LONG_FORM | 8'h02, CHK_QUIET, '0},
    '{8'h03, CHK_QUIET, '0},
    '{8'hE8, CHK_TYPED, '{KIND_TOO_LONG, 8'h00, 16'h0000}},
    '{TAG_BYTE, CHK_QUIET, '0},
    '{LONG_FORM | 8'h03, CHK_QUIET, '0},      // top byte wraps out
    '{8'hAB, CHK_PRED, '0},
    '{8'h00, CHK_PRED, '0},
    '{8'h01, CHK_PRED, '0},
    '{8'h7E, CHK_TYPED, '{KIND_LAST, 8'h7E, 16'h0000}},
    '{TAG_BYTE, CHK_QUIET, '0},
    '{LONG_FORM | 8'h02, CHK_QUIET, '0},
    '{8'h00, CHK_QUIET, '0},
    '{8'h00, CHK_TYPED, '{KIND_EMPTY, 8'h00, 16'h0000}}
  };

  ber_tlv_frame_extractor DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic void go_hunt();
    ph = PH_HUNT;
    len_left = '0;
    pay_left = '0;
    pay_pos = '0;
  endfunction

  // advances the parser by one byte, returns 1 when a result item is due
  function automatic bit parse_byte(input logic [7:0] c, output result_t r);
    r = '0;
    case (ph)
      PH_LEN: begin
        if (len_left == 0) begin
          if (c < LONG_FORM) begin
            pay_left = {8'h00, c};
            pay_pos = '0;
            if (c == 0) begin
              go_hunt();
              r.kind = KIND_EMPTY;
              return 1'b1;
            end
            ph = PH_DATA;
          end else begin
            len_left = c[6:0];
            pay_left = '0;
          end
          return 1'b0;
        end
        pay_left = {pay_left[7:0], c};
        len_left = len_left - 7'd1;
        if (len_left != 0) return 1'b0;
        if (pay_left >= max_len) begin
          go_hunt();
          r.kind = KIND_TOO_LONG;
          return 1'b1;
        end
        if (pay_left == 0) begin
          go_hunt();
          r.kind = KIND_EMPTY;
          return 1'b1;
        end
        ph = PH_DATA;
        pay_pos = '0;
        return 1'b0;
      end
      PH_DATA: begin
        r.data = c;
        r.index = pay_pos;
        pay_pos = pay_pos + 16'd1;
        pay_left = pay_left - 16'd1;
        if (pay_left == 0) begin
          go_hunt();
          r.kind = KIND_LAST;
        end else begin
          r.kind = KIND_DATA;
        end
        return 1'b1;
      end
      default: begin
        go_hunt();
        if (c == TAG_BYTE) ph = PH_LEN;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want_v);
    errors++;
    if (errors <= 40)
      $display("mismatch at cycle %0d, %s: got %0h expected %0h", cycles, what, got, want_v);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report("unexpected result item, kind", {14'd0, m_tuser}, 16'd0);
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.kind) report("result_kind", {14'd0, m_tuser}, {14'd0, want.kind});
        if (m_tdata[7:0] !== want.data) report("data_byte", {8'd0, m_tdata[7:0]}, {8'd0, want.data});
        if (m_tdata[23:8] !== want.index) report("byte_index", m_tdata[23:8], want.index);
      end
    end
  end

  // receiver backpressure
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_idle && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input chk_t how = CHK_PRED,
                           input result_t want = '0);
    int      gap;
    result_t r;
    bit      gives;
    gap = (tx_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      s_tdata <= 8'($urandom);
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    gives = parse_byte(b, r);
    if (how == CHK_TYPED) pending_results.push_back(want);
    else if (how == CHK_PRED && gives) pending_results.push_back(r);
    sent_items++;
  endtask

  // drop valid and wait until every expected item is out and the pipe is empty
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_max_length(input logic [15:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    max_len = v;
  endtask

  // nb = 0 means short form; length bytes above the low two wrap out
  task automatic send_frame(input int len, input int nb, input int nz);
    int i;
    send_byte(TAG_BYTE);
    repeat (nz) send_byte(LONG_FORM);
    if (nb == 0) begin
      send_byte(len[7:0]);
    end else begin
      send_byte(LONG_FORM | nb[7:0]);
      for (i = nb - 1; i >= 0; i--)
        send_byte(i >= 2 ? 8'($urandom) : len[8*i +: 8]);
    end
    if (nb == 0 || len < max_len)
      repeat (len) send_byte(8'($urandom));
  endtask

  task automatic random_frame();
    int         len;
    int         nb;
    int         nz;
    int         pick;
    logic [7:0] junk;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        junk = 8'($urandom);
        if (junk == TAG_BYTE) junk = ~junk;
        send_byte(junk);
      end
    end
    pick = $urandom_range(0, 9);
    if (pick < 6) len = $urandom_range(0, 24);
    else if (pick < 8) len = $urandom_range(100, 300);
    else if (pick == 8) len = $urandom_range(max_len, 65535);
    else if (max_len <= 400) len = max_len - $urandom_range(0, 1);
    else len = $urandom_range(127, 128);
    if (len < 128 && $urandom_range(0, 1) == 0) nb = 0;
    else if ($urandom_range(0, 15) == 0) nb = $urandom_range(0, 1) ? 127 : $urandom_range(3, 8);
    else if (len < 256 && $urandom_range(0, 1) == 0) nb = 1;
    else nb = 2;
    nz = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0;
    send_frame(len, nb, nz);
  endtask

  initial begin
    int          i;
    int          p;
    int          target;
    logic [15:0] next_max;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'h00;
    cfg_we = 1'b0;
    cfg_data = 16'h0000;
    go_hunt();
    max_len = MAX_LENGTH_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < $size(DIRECTED); i++)
      send_byte(DIRECTED[i].b, DIRECTED[i].how, DIRECTED[i].want);

    for (p = 0; p < 5; p++) begin
      case (p)
        0: next_max = 16'd128;
        1: next_max = 16'hFFFF;
        2: next_max = 16'($urandom_range(128, 65535));
        3: next_max = 16'd300;
        default: next_max = 16'hFFFF;
      endcase
      if (p == 4) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end
      write_max_length(next_max);
      target = sent_items + 400;
      while (sent_items < target) begin
        if (p < 4) begin
          tx_idle = $urandom_range(0, 3) != 0;
          rx_idle = $urandom_range(0, 3) != 0;
        end
        random_frame();
      end
    end

    drain();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
